// ----- hdl/kdrs_pkg.sv -----
// shared types and constants for the keypad debounce and repeat scanner
`default_nettype none

package kdrs_pkg;

   localparam int unsigned KDRS_NUM_KEYS        = 16;
   localparam int unsigned KDRS_KEY_W           = 4;
   localparam int unsigned KDRS_QUEUE_DEPTH     = 16;
   localparam int unsigned KDRS_POLL_FIFO_DEPTH = 2;
   localparam int unsigned KDRS_REQ_TDATA_W     = 48;
   localparam int unsigned KDRS_RSP_TDATA_W     = 8;
   localparam int unsigned KDRS_CSR_INDEX_W     = 2;
   localparam int unsigned KDRS_CSR_DATA_W      = 16;

   // register indexes of the configuration port
   typedef enum logic [KDRS_CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE_MS     = 2'd0,
      CSR_REPEAT_DELAY_MS = 2'd1,
      CSR_REPEAT_RATE_MS  = 2'd2
   } kdrs_csr_type;

   typedef struct packed {
      logic [7:0]  debounce_ms;
      logic [15:0] repeat_delay_ms;
      logic [15:0] repeat_rate_ms;
   } kdrs_cfg_type;

   // one poll: now_ms in the upper bits, pressed_keys in the lower
   typedef struct packed {
      logic [31:0] now_ms;
      logic [15:0] pressed_keys;
   } kdrs_poll_type;

   // one result: key_valid lowest
   typedef struct packed {
      logic                  keys_dropped;
      logic [KDRS_KEY_W-1:0] key_index;
      logic                  key_valid;
   } kdrs_result_type;

endpackage

`default_nettype wire

// ----- hdl/kdrs_poll_fifo.sv -----
// front end: accepts poll items and buffers them for the scan engine
`default_nettype none

module kdrs_poll_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire kdrs_pkg::kdrs_poll_type in_item,
   output logic                        out_valid,
   input  wire logic                   out_pop,
   output kdrs_pkg::kdrs_poll_type     out_item
);
   import kdrs_pkg::*;

   localparam int unsigned PTR_W = $clog2(KDRS_POLL_FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(KDRS_POLL_FIFO_DEPTH + 1);

   kdrs_poll_type entry_ff [KDRS_POLL_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(KDRS_POLL_FIFO_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(KDRS_POLL_FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(KDRS_POLL_FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kdrs_scan_engine.sv -----
// back end: auto-repeat, key scan, key queue and result register
`default_nettype none

module kdrs_scan_engine #(
   parameter  int unsigned QUEUE_DEPTH = kdrs_pkg::KDRS_QUEUE_DEPTH,
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire kdrs_pkg::kdrs_cfg_type   cfg,
   input  wire logic                     poll_valid,
   input  wire kdrs_pkg::kdrs_poll_type  poll_item,
   output logic                          poll_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output kdrs_pkg::kdrs_result_type     rsp_result,
   output logic [QCNT_W-1:0]             queue_count
);
   import kdrs_pkg::*;

   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

   localparam int unsigned FLAG_PRESS = 0;
   localparam int unsigned FLAG_DOWN  = 1;
   localparam int unsigned FLAG_SENT  = 2;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REPEAT = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_READ   = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      RPT_IDLE   = 3'b001,
      RPT_DELAY  = 3'b010,
      RPT_ACTIVE = 3'b100
   } phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [15:0]           pressed_ff;
   logic [31:0]           now_ff;
   logic [KDRS_KEY_W-1:0] key_cnt_ff, key_cnt_in;
   logic [KDRS_KEY_W-1:0] last_key_ff, last_key_in;
   logic [31:0]           mark_ff, mark_in;
   logic [2:0]            flags_ff [KDRS_NUM_KEYS];
   logic [31:0]           start_ff [KDRS_NUM_KEYS];

   logic [KDRS_KEY_W-1:0] queue_mem [QUEUE_DEPTH];
   logic [KDRS_KEY_W-1:0] q_rd_data_ff;
   logic [QPTR_W-1:0]     q_wr_ptr_ff, q_wr_ptr_in;
   logic [QPTR_W-1:0]     q_rd_ptr_ff, q_rd_ptr_in;
   logic [QCNT_W-1:0]     q_count_ff, q_count_in;
   logic                  drop_ff, drop_in;
   logic                  q_full;
   logic                  q_write;

   logic                  rsp_valid_ff, rsp_valid_in;
   kdrs_result_type       rsp_result_ff, rsp_result_in;

   logic [KDRS_KEY_W-1:0] flag_sel;
   logic [2:0]            cur_flags;
   logic [2:0]            flags_wr_val;
   logic                  flags_wr_en;
   logic                  start_wr_en;
   logic                  key_pressed;
   logic                  rpt_armed;
   logic [15:0]           rate_eff;
   logic [31:0]           time_ref;
   logic [31:0]           time_limit;
   logic [31:0]           elapsed;
   logic                  passed;
   logic                  enq_req;
   logic [KDRS_KEY_W-1:0] enq_key;
   logic                  emit;

   // shared flag read port: last sent key during the repeat step, scan key otherwise
   assign flag_sel    = (state_ff == ST_REPEAT) ? last_key_ff : key_cnt_ff;
   assign cur_flags   = flags_ff[flag_sel];
   assign key_pressed = pressed_ff[key_cnt_ff];
   assign rpt_armed   = ((phase_ff == RPT_DELAY) || (phase_ff == RPT_ACTIVE)) &&
                        cur_flags[FLAG_DOWN];
   assign rate_eff    = (cfg.repeat_rate_ms != 16'd0) ? cfg.repeat_rate_ms :
                        {2'b00, cfg.repeat_delay_ms[15:2]};

   // one elapsed-time compare per cycle, wraps modulo 2^32
   always_comb begin
      if (state_ff == ST_REPEAT) begin
         time_ref   = mark_ff;
         time_limit = (phase_ff == RPT_DELAY) ? {16'd0, cfg.repeat_delay_ms} :
                                                {16'd0, rate_eff};
      end else begin
         time_ref   = start_ff[key_cnt_ff];
         time_limit = {24'd0, cfg.debounce_ms};
      end
   end

   assign elapsed = now_ff - time_ref;
   assign passed  = (elapsed > time_limit);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      key_cnt_in   = key_cnt_ff;
      last_key_in  = last_key_ff;
      mark_in      = mark_ff;
      flags_wr_en  = 1'b0;
      flags_wr_val = cur_flags;
      start_wr_en  = 1'b0;
      enq_req      = 1'b0;
      enq_key      = last_key_ff;
      poll_pop     = 1'b0;
      emit         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (poll_valid) begin
               poll_pop = 1'b1;
               state_in = ST_REPEAT;
            end
         end
         ST_REPEAT: begin
            if (rpt_armed) begin
               if (passed) begin
                  enq_req  = 1'b1;
                  mark_in  = now_ff;
                  phase_in = RPT_ACTIVE;
               end
            end else begin
               phase_in = RPT_IDLE;
            end
            key_cnt_in = '0;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            flags_wr_en = 1'b1;
            if (!key_pressed) begin
               if (cur_flags[FLAG_DOWN]) begin
                  flags_wr_val = 3'b000;
               end
            end else if (cur_flags[FLAG_DOWN]) begin
               if (!cur_flags[FLAG_SENT]) begin
                  enq_req                 = 1'b1;
                  enq_key                 = key_cnt_ff;
                  last_key_in             = key_cnt_ff;
                  flags_wr_val[FLAG_SENT] = 1'b1;
                  if (cfg.repeat_delay_ms != 16'd0) begin
                     mark_in  = now_ff;
                     phase_in = RPT_DELAY;
                  end
               end
            end else if (cur_flags[FLAG_PRESS]) begin
               if (passed) begin
                  flags_wr_val[FLAG_DOWN] = 1'b1;
               end
            end else begin
               start_wr_en              = 1'b1;
               flags_wr_val[FLAG_PRESS] = 1'b1;
            end
            key_cnt_in = key_cnt_ff + 1'b1;
            if (key_cnt_ff == KDRS_KEY_W'(KDRS_NUM_KEYS - 1)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // key queue bookkeeping; enqueue and dequeue never share a cycle
   assign q_full  = (q_count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_write = enq_req && !q_full;

   always_comb begin
      q_wr_ptr_in = q_wr_ptr_ff;
      q_rd_ptr_in = q_rd_ptr_ff;
      q_count_in  = q_count_ff;
      drop_in     = drop_ff;
      if (poll_pop) begin
         drop_in = 1'b0;
      end
      if (enq_req) begin
         if (q_full) begin
            drop_in = 1'b1;
         end else begin
            q_wr_ptr_in = (q_wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          q_wr_ptr_ff + 1'b1;
            q_count_in  = q_count_ff + 1'b1;
         end
      end
      if (emit && (q_count_ff != '0)) begin
         q_rd_ptr_in = (q_rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                       q_rd_ptr_ff + 1'b1;
         q_count_in  = q_count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_result_in = rsp_result_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in               = 1'b1;
         rsp_result_in.key_valid    = (q_count_ff != '0);
         rsp_result_in.key_index    = (q_count_ff != '0) ? q_rd_data_ff : '0;
         rsp_result_in.keys_dropped = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= RPT_IDLE;
         key_cnt_ff   <= '0;
         last_key_ff  <= '0;
         q_wr_ptr_ff  <= '0;
         q_rd_ptr_ff  <= '0;
         q_count_ff   <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KDRS_NUM_KEYS; i++) begin
            flags_ff[i] <= 3'b000;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         key_cnt_ff   <= key_cnt_in;
         last_key_ff  <= last_key_in;
         q_wr_ptr_ff  <= q_wr_ptr_in;
         q_rd_ptr_ff  <= q_rd_ptr_in;
         q_count_ff   <= q_count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (flags_wr_en) begin
            flags_ff[key_cnt_ff] <= flags_wr_val;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mark_ff       <= mark_in;
      rsp_result_ff <= rsp_result_in;
      if (poll_pop) begin
         pressed_ff <= poll_item.pressed_keys;
         now_ff     <= poll_item.now_ms;
      end
      if (start_wr_en) begin
         start_ff[key_cnt_ff] <= now_ff;
      end
   end

   // key queue memory, registered read of the head
   always_ff @(posedge clock) begin
      if (q_write) begin
         queue_mem[q_wr_ptr_ff] <= enq_key;
      end
      q_rd_data_ff <= queue_mem[q_rd_ptr_ff];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_result  = rsp_result_ff;
   assign queue_count = q_count_ff;

endmodule

`default_nettype wire

// ----- hdl/keypad_debounce_repeat_scanner_core.sv -----
// top level of the keypad debounce and auto-repeat scanner
`default_nettype none

// channel   dir  payload                                   accepted when
// req_      in   tdata: pressed_keys[15:0], now_ms[47:16]   req_tvalid & req_tready
// rsp_      out  tdata: key_valid[0], key_index[4:1],       rsp_tvalid & rsp_tready
//                       keys_dropped[5], zero [7:6]
// csr_      in   index 0 debounce, 1 repeat delay, 2 rate   csr_wr_en
//
// each poll passes through the scan engine in order: dequeue, the auto-repeat
// step, the key walk over all sixteen keys (one key per cycle through the
// shared flag and start-time read port), the key queue read and the load of the
// result register; the engine takes no new poll until it is back in idle
// reset is synchronous and clears flags, repeat phase, queue pointers and valids
// a two-entry poll buffer keeps taking items, until it is full, while the engine
// works or while a result waits on rsp_tready; the engine holds in its emit step
// until the result register is free

module keypad_debounce_repeat_scanner_core #(
   parameter int unsigned QUEUE_DEPTH = kdrs_pkg::KDRS_QUEUE_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // pressed_keys[15:0], now_ms[47:16]
   input  wire logic [kdrs_pkg::KDRS_REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // key_valid[0], key_index[4:1], keys_dropped[5], zero pad [7:6]
   output logic [kdrs_pkg::KDRS_RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic                                   csr_wr_en,
   input  wire logic [kdrs_pkg::KDRS_CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [kdrs_pkg::KDRS_CSR_DATA_W-1:0]   csr_wr_data
);
   import kdrs_pkg::*;

   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   kdrs_cfg_type    cfg_ff, cfg_in;
   kdrs_poll_type   req_item;
   kdrs_poll_type   poll_item;
   logic            poll_valid;
   logic            poll_pop;
   kdrs_result_type rsp_result;
   logic [QCNT_W-1:0] queue_count;

   // configuration registers; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE_MS:     cfg_in.debounce_ms     = csr_wr_data[7:0];
            CSR_REPEAT_DELAY_MS: cfg_in.repeat_delay_ms = csr_wr_data;
            CSR_REPEAT_RATE_MS:  cfg_in.repeat_rate_ms  = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // unpack the request word
   assign req_item.pressed_keys = req_tdata[15:0];
   assign req_item.now_ms       = req_tdata[47:16];

   // front: poll buffer
   kdrs_poll_fifo u_poll_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (poll_valid),
      .out_pop   (poll_pop),
      .out_item  (poll_item)
   );

   // back: repeat, scan, key queue, result register
   kdrs_scan_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_scan_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .poll_valid  (poll_valid),
      .poll_item   (poll_item),
      .poll_pop    (poll_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (rsp_result),
      .queue_count (queue_count)
   );

   // pack the result, pad to a whole byte
   assign rsp_tdata = {2'b00, rsp_result};

   // no key index without a delivered key
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[4:1] == 4'd0))
      else $error("key index set on an empty result");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // the key queue never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      queue_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("key queue count beyond depth");

   // the engine only takes a poll the buffer actually holds
   assert property (@(posedge clock) disable iff (reset)
      poll_pop |-> poll_valid)
      else $error("poll taken from an empty buffer");

endmodule

`default_nettype wire
